@@ hdl/lpmr_pkg.sv @@
// Shared types and constants for the length-prefixed message ring.
// No dependencies; imported by the top level, lpmr_ctrl and lpmr_dp.
package lpmr_pkg;

	localparam int unsigned RING_BYTES_DEF = 32768;

	typedef enum logic [1:0] {
		OP_PUT_BEGIN = 2'd0,
		OP_PUT_BYTE  = 2'd1,
		OP_GET_BEGIN = 2'd2,
		OP_GET_BYTE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_TOO_LONG = 3'd3,
		ST_NOT_OPEN = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALIGN,
		S_CHECK,
		S_HDR,
		S_HWAIT,
		S_FIN,
		S_BYTE,
		S_BWAIT,
		S_RESP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;
		logic align;
		logic check;
		logic hdr;
		logic fin;
		logic byte_go;
		logic byte_end;
		logic load;
	} lpmr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_t  op;
		logic fail;
		logic open;
		logic cnt_last;
		logic out_free;
	} lpmr_stat_t;

endpackage

@@ hdl/length_prefixed_message_ring.sv @@
// Channel  Handshake             Payload
// in       in_valid / in_ready   op, msg_len, data_byte, max_len
// out      out_valid / out_ready status, out_len, out_byte, last
//
// Each transaction is stepped by the state sequencer: a get byte waits on the
// registered byte RAM read, and put begin and get begin move the four header
// bytes one at a time through the byte-wide RAM port.
// A result sits in the output register while the next transaction is taken.
// arst_n clears offsets, cursors, open flags and the output valid; ring
// contents are not cleared. A stalled output holds the sequencer in its
// response state. RING_BYTES must be a power of two.
// Top level; depends on lpmr_pkg, lpmr_ctrl, lpmr_dp.
module length_prefixed_message_ring_core #(
	parameter int unsigned RING_BYTES = lpmr_pkg::RING_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [14:0] msg_len,
	input  logic [7:0]  data_byte,
	input  logic [14:0] max_len,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [14:0] out_len,
	output logic [7:0]  out_byte,
	output logic        last
);

	import lpmr_pkg::*;

	lpmr_cmd_t  cmd;
	lpmr_stat_t stat;

	lpmr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.op      (op),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	lpmr_dp #(
		.RING_BYTES(RING_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.op       (op),
		.msg_len  (msg_len),
		.data_byte(data_byte),
		.max_len  (max_len),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.out_len  (out_len),
		.out_byte (out_byte),
		.last     (last)
	);

endmodule

@@ hdl/lpmr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpmr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/lpmr_ctrl.sv @@
// Controller state machine for the message ring.
// Depends on lpmr_pkg; drives lpmr_dp through lpmr_cmd_t.
module lpmr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         op,
	output logic               in_ready,
	input  lpmr_pkg::lpmr_stat_t stat,
	output lpmr_pkg::lpmr_cmd_t  cmd
);

	import lpmr_pkg::*;

	state_t state_q, state_nxt, dispatch;
	logic   accept;

	always_comb begin
		if (op_t'(op) inside {OP_PUT_BEGIN, OP_GET_BEGIN}) begin
			dispatch = S_ALIGN;
		end else begin
			dispatch = S_BYTE;
		end
	end

	assign in_ready = (state_q == S_IDLE) || (state_q == S_RESP && stat.out_free);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_nxt = dispatch;
			end
			S_ALIGN: state_nxt = S_CHECK;
			S_CHECK: begin
				state_nxt = stat.fail ? S_RESP : S_HDR;
			end
			S_HDR: begin
				if (stat.cnt_last) begin
					state_nxt = (stat.op == OP_GET_BEGIN) ? S_HWAIT : S_FIN;
				end
			end
			S_HWAIT: state_nxt = S_FIN;
			S_FIN:   state_nxt = S_RESP;
			S_BYTE: begin
				state_nxt = (stat.op == OP_GET_BYTE && stat.open) ? S_BWAIT : S_RESP;
			end
			S_BWAIT: state_nxt = S_RESP;
			S_RESP: begin
				if (stat.out_free) state_nxt = accept ? dispatch : S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.latch    = accept;
		cmd.align    = (state_q == S_ALIGN);
		cmd.check    = (state_q == S_CHECK);
		cmd.hdr      = (state_q == S_HDR);
		cmd.fin      = (state_q == S_FIN);
		cmd.byte_go  = (state_q == S_BYTE);
		cmd.byte_end = (state_q == S_BWAIT);
		cmd.load     = (state_q == S_RESP) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ hdl/lpmr_dp.sv @@
// Datapath for the message ring: offsets, cursors, header assembly, result registers.
// Depends on lpmr_pkg and lpmr_ram; commanded by lpmr_ctrl.
module lpmr_dp #(
	parameter int unsigned RING_BYTES = lpmr_pkg::RING_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lpmr_pkg::lpmr_cmd_t  cmd,
	output lpmr_pkg::lpmr_stat_t stat,
	input  logic [1:0]           op,
	input  logic [14:0]          msg_len,
	input  logic [7:0]           data_byte,
	input  logic [14:0]          max_len,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic [14:0]          out_len,
	output logic [7:0]           out_byte,
	output logic                 last
);

	import lpmr_pkg::*;

	// the user must keep RING_BYTES a power of two, the block does not check it; slot index is the low offset bits
	localparam int unsigned AW       = $clog2(RING_BYTES);
	localparam logic [33:0] RING_LIM = 34'(RING_BYTES);

	op_t         op_q;
	logic [14:0] msg_len_q, max_len_q;
	logic [7:0]  data_q;

	logic [31:0] a_q, ro_q, wo_q, wc_q, rc_q, hdr_q;
	logic [14:0] prem_q, grem_q;
	logic        popen_q, gopen_q;
	logic [1:0]  cnt_q;
	logic        cap_s1;

	status_t     res_status_q;
	logic [14:0] res_len_q;
	logic [7:0]  res_byte_q;
	logic        res_last_q;

	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [14:0] out_len_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	logic [31:0] diff, span, align_src;
	logic [33:0] need;
	logic        full, empty;
	logic        ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr, hdr_addr;
	logic [7:0]  ram_wdata, ram_rdata, hdr_byte;
	logic        put_go, get_go;

	assign diff  = a_q - ro_q;
	assign need  = {2'b00, diff} + 34'd4 + {19'd0, msg_len_q};
	assign full  = need > RING_LIM;
	assign span  = wo_q - a_q;
	assign empty = (span == 32'd0) || span[31];

	assign align_src = (op_q == OP_PUT_BEGIN) ? wo_q : ro_q;

	assign stat.op       = op_q;
	assign stat.fail     = (op_q == OP_PUT_BEGIN) ? full : empty;
	assign stat.open     = (op_q == OP_PUT_BYTE) ? popen_q : gopen_q;
	assign stat.cnt_last = (cnt_q == 2'd3);
	assign stat.out_free = !out_valid_q || out_ready;

	always_comb begin
		case (cnt_q)
			2'd0:    hdr_byte = msg_len_q[7:0];
			2'd1:    hdr_byte = {1'b0, msg_len_q[14:8]};
			default: hdr_byte = 8'd0;
		endcase
	end

	assign hdr_addr  = {a_q[AW-1:2], cnt_q};
	assign put_go    = cmd.byte_go && (op_q == OP_PUT_BYTE) && popen_q;
	assign get_go    = cmd.byte_go && (op_q == OP_GET_BYTE) && gopen_q;
	assign ram_we    = (cmd.hdr && op_q == OP_PUT_BEGIN) || put_go;
	assign ram_waddr = cmd.hdr ? hdr_addr : wc_q[AW-1:0];
	assign ram_wdata = cmd.hdr ? hdr_byte : data_q;
	assign ram_re    = (cmd.hdr && op_q == OP_GET_BEGIN) || get_go;
	assign ram_raddr = cmd.hdr ? hdr_addr : rc_q[AW-1:0];

	lpmr_ram #(
		.WIDTH(8),
		.DEPTH(RING_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// latched transaction, aligned offset and header shift register
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q      <= op_t'(op);
			msg_len_q <= msg_len;
			data_q    <= data_byte;
			max_len_q <= max_len;
		end
		if (cmd.align) begin
			a_q <= (align_src + 32'd3) & ~32'h0000_0003;
		end
		if (cap_s1) begin
			hdr_q <= {ram_rdata, hdr_q[31:8]};
		end
	end

	// ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ro_q    <= '0;
			wo_q    <= '0;
			wc_q    <= '0;
			rc_q    <= '0;
			prem_q  <= '0;
			grem_q  <= '0;
			popen_q <= 1'b0;
			gopen_q <= 1'b0;
			cnt_q   <= '0;
			cap_s1  <= 1'b0;
		end else begin
			cap_s1 <= cmd.hdr && (op_q == OP_GET_BEGIN);
			if (cmd.align) begin
				cnt_q <= '0;
				if (op_q == OP_PUT_BEGIN) popen_q <= 1'b0;
				else gopen_q <= 1'b0;
			end
			if (cmd.hdr) cnt_q <= cnt_q + 2'd1;
			if (cmd.fin) begin
				if (op_q == OP_PUT_BEGIN) begin
					if (msg_len_q == 15'd0) begin
						wo_q <= a_q + 32'd4;
					end else begin
						wc_q    <= a_q + 32'd4;
						prem_q  <= msg_len_q;
						popen_q <= 1'b1;
					end
				end else if (hdr_q <= {17'd0, max_len_q}) begin
					if (hdr_q == 32'd0) begin
						ro_q <= a_q + 32'd4;
					end else begin
						rc_q    <= a_q + 32'd4;
						grem_q  <= hdr_q[14:0];
						gopen_q <= 1'b1;
					end
				end
			end
			if (put_go) begin
				wc_q   <= wc_q + 32'd1;
				prem_q <= prem_q - 15'd1;
				if (prem_q == 15'd1) begin
					wo_q    <= wc_q + 32'd1;
					popen_q <= 1'b0;
				end
			end
			if (cmd.byte_end) begin
				rc_q   <= rc_q + 32'd1;
				grem_q <= grem_q - 15'd1;
				if (grem_q == 15'd1) begin
					ro_q    <= rc_q + 32'd1;
					gopen_q <= 1'b0;
				end
			end
		end
	end

	// result capture and output register load
	always_ff @(posedge clk) begin
		if (cmd.check && stat.fail) begin
			res_status_q <= (op_q == OP_PUT_BEGIN) ? ST_FULL : ST_EMPTY;
			res_len_q    <= '0;
			res_byte_q   <= '0;
			res_last_q   <= 1'b0;
		end
		if (cmd.fin) begin
			res_byte_q <= '0;
			if (op_q == OP_PUT_BEGIN) begin
				res_status_q <= ST_OK;
				res_len_q    <= '0;
				res_last_q   <= (msg_len_q == 15'd0);
			end else begin
				res_len_q <= hdr_q[14:0];
				if (hdr_q > {17'd0, max_len_q}) begin
					res_status_q <= ST_TOO_LONG;
					res_last_q   <= 1'b0;
				end else begin
					res_status_q <= ST_OK;
					res_last_q   <= (hdr_q == 32'd0);
				end
			end
		end
		if (cmd.byte_go && !get_go) begin
			res_status_q <= put_go ? ST_OK : ST_NOT_OPEN;
			res_len_q    <= '0;
			res_byte_q   <= '0;
			res_last_q   <= put_go && (prem_q == 15'd1);
		end
		if (cmd.byte_end) begin
			res_status_q <= ST_OK;
			res_len_q    <= '0;
			res_byte_q   <= ram_rdata;
			res_last_q   <= (grem_q == 15'd1);
		end
		if (cmd.load) begin
			out_status_q <= res_status_q;
			out_len_q    <= res_len_q;
			out_byte_q   <= res_byte_q;
			out_last_q   <= res_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign out_len   = out_len_q;
	assign out_byte  = out_byte_q;
	assign last      = out_last_q;

endmodule

@@ dv/tb_length_prefixed_message_ring_core.sv @@
// Self-checking testbench for length_prefixed_message_ring_core: a directed table,
// then random message traffic and a final drain, checked against a predictor.
// Depends on lpmr_pkg and the core RTL only.
module tb_length_prefixed_message_ring_core;
	import lpmr_pkg::*;

	localparam bit [31:0]   RING    = RING_BYTES_DEF;
	localparam int unsigned RING_AW = $clog2(RING_BYTES_DEF);

	typedef struct packed {
		status_t     st;
		logic [14:0] len;
		logic [7:0]  data;
		logic        last;
	} ring_result_t;

	typedef struct packed {
		op_t          cmd;
		logic [14:0]  len;
		logic [7:0]   din;
		logic [14:0]  lim;
		bit           typed;
		ring_result_t want;
	} op_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [14:0] msg_len;
	logic [7:0]  data_byte;
	logic [14:0] max_len;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [14:0] out_len;
	logic [7:0]  out_byte;
	logic        last;

	// predictor copy of the ring
	logic [7:0]  ring_mem [RING];
	bit [31:0]   rd_off, wr_off, wr_cur, rd_cur;
	bit [14:0]   put_left, get_left;
	bit          put_busy, get_busy;

	ring_result_t pending_results[$];
	ring_result_t head_result;
	op_row_t      dir_rows [25];
	int           mismatch_count;
	int           items_sent;
	int           send_idle;
	int           recv_idle;
	int           stall_left;

	length_prefixed_message_ring_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.msg_len(msg_len),
		.data_byte(data_byte),
		.max_len(max_len),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_len(out_len),
		.out_byte(out_byte),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic bit [RING_AW-1:0] slot(bit [31:0] off);
		return off[RING_AW-1:0];
	endfunction

	function automatic ring_result_t ring_step(op_t cmd, logic [14:0] len, logic [7:0] din,
			logic [14:0] lim);
		ring_result_t r;
		bit [31:0]    a;
		bit [31:0]    d;
		bit [31:0]    hdr;
		r = '0;
		case (cmd)
			OP_PUT_BEGIN: begin
				put_busy = 1'b0;
				a = (wr_off + 32'd3) & ~32'd3;
				d = a - rd_off;
				if (64'(d) + 64'd4 + 64'(len) > 64'(RING)) begin
					r.st = ST_FULL;
				end else begin
					ring_mem[slot(a)] = len[7:0];
					ring_mem[slot(a + 32'd1)] = {1'b0, len[14:8]};
					ring_mem[slot(a + 32'd2)] = 8'd0;
					ring_mem[slot(a + 32'd3)] = 8'd0;
					if (len == 15'd0) begin
						wr_off = a + 32'd4;
						r.last = 1'b1;
					end else begin
						wr_cur = a + 32'd4;
						put_left = len;
						put_busy = 1'b1;
					end
				end
			end
			OP_PUT_BYTE: begin
				if (!put_busy) begin
					r.st = ST_NOT_OPEN;
				end else begin
					ring_mem[slot(wr_cur)] = din;
					wr_cur = wr_cur + 32'd1;
					put_left = put_left - 15'd1;
					if (put_left == 15'd0) begin
						wr_off = wr_cur;
						put_busy = 1'b0;
						r.last = 1'b1;
					end
				end
			end
			OP_GET_BEGIN: begin
				get_busy = 1'b0;
				a = (rd_off + 32'd3) & ~32'd3;
				d = wr_off - a;
				if (d == 32'd0 || d[31]) begin
					r.st = ST_EMPTY;
				end else begin
					hdr = {ring_mem[slot(a + 32'd3)], ring_mem[slot(a + 32'd2)],
						ring_mem[slot(a + 32'd1)], ring_mem[slot(a)]};
					r.len = hdr[14:0];
					if (hdr > 32'(lim)) begin
						r.st = ST_TOO_LONG;
					end else if (hdr == 32'd0) begin
						rd_off = a + 32'd4;
						r.last = 1'b1;
					end else begin
						rd_cur = a + 32'd4;
						get_left = hdr[14:0];
						get_busy = 1'b1;
					end
				end
			end
			default: begin
				if (!get_busy) begin
					r.st = ST_NOT_OPEN;
				end else begin
					r.data = ring_mem[slot(rd_cur)];
					rd_cur = rd_cur + 32'd1;
					get_left = get_left - 15'd1;
					if (get_left == 15'd0) begin
						rd_off = rd_cur;
						get_busy = 1'b0;
						r.last = 1'b1;
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d, want %0d", what, got, want);
		mismatch_count++;
	endtask

	task automatic idle_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic offer_op(op_t cmd, logic [14:0] len, logic [7:0] din, logic [14:0] lim,
			bit typed, ring_result_t want);
		ring_result_t r;
		while ($urandom_range(99) < send_idle)
			idle_input();
		@(negedge clk);
		in_valid <= 1'b1;
		op <= cmd;
		msg_len <= len;
		data_byte <= din;
		max_len <= lim;
		do @(posedge clk); while (!in_ready);
		r = ring_step(cmd, len, din, lim);
		pending_results.push_back(typed ? want : r);
		items_sent++;
	endtask

	task automatic settle();
		idle_input();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic put_message(int n, bit finish);
		offer_op(OP_PUT_BEGIN, 15'(n), 8'($urandom), 15'($urandom), 1'b0, '0);
		while (put_busy && (finish || $urandom_range(19) != 0))
			offer_op(OP_PUT_BYTE, 15'($urandom), 8'($urandom), 15'($urandom), 1'b0, '0);
	endtask

	task automatic get_message(logic [14:0] lim, bit finish);
		offer_op(OP_GET_BEGIN, 15'($urandom), 8'($urandom), lim, 1'b0, '0);
		while (get_busy && (finish || $urandom_range(19) != 0))
			offer_op(OP_GET_BYTE, 15'($urandom), 8'($urandom), 15'($urandom), 1'b0, '0);
	endtask

	task automatic random_traffic(int count);
		int stop;
		int k;
		stop = items_sent + count;
		while (items_sent < stop) begin
			k = $urandom_range(99);
			if (k < 40) begin
				put_message(($urandom_range(9) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12),
					$urandom_range(9) != 0);
			end else if (k < 78) begin
				get_message(($urandom_range(3) == 0) ? 15'($urandom) : 15'h7fff,
					$urandom_range(9) != 0);
			end else if (k < 88) begin
				offer_op($urandom_range(1) ? OP_PUT_BYTE : OP_GET_BYTE, 15'($urandom),
					8'($urandom), 15'($urandom), 1'b0, '0);
			end else if (k < 94) begin
				get_message(15'($urandom_range(0, 8)), 1'b1);
			end else begin
				offer_op(OP_PUT_BEGIN, 15'($urandom), 8'($urandom), 15'($urandom), 1'b0, '0);
			end
		end
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result with no transaction pending", status, 0);
			end else begin
				head_result = pending_results.pop_front();
				if (status !== head_result.st)
					flag_mismatch("status", status, head_result.st);
				if (out_len !== head_result.len)
					flag_mismatch("out_len", out_len, head_result.len);
				if (out_byte !== head_result.data)
					flag_mismatch("out_byte", out_byte, head_result.data);
				if (last !== head_result.last)
					flag_mismatch("last", last, head_result.last);
			end
		end
	end

	initial begin
		bit [31:0] d;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_PUT_BEGIN;
		msg_len = '0;
		data_byte = '0;
		max_len = '0;
		rd_off = '0;
		wr_off = '0;
		wr_cur = '0;
		rd_cur = '0;
		put_left = '0;
		get_left = '0;
		put_busy = 1'b0;
		get_busy = 1'b0;
		mismatch_count = 0;
		items_sent = 0;
		stall_left = 0;
		send_idle = 13;
		recv_idle = 81;

		dir_rows = '{
			'{OP_GET_BEGIN, 15'd0, 8'h00, 15'd0, 1'b1, '{ST_EMPTY, 15'd0, 8'h00, 1'b0}},
			'{OP_GET_BYTE, 15'd0, 8'h00, 15'd0, 1'b1, '{ST_NOT_OPEN, 15'd0, 8'h00, 1'b0}},
			'{OP_PUT_BYTE, 15'd0, 8'hff, 15'd0, 1'b1, '{ST_NOT_OPEN, 15'd0, 8'h00, 1'b0}},
			'{OP_PUT_BEGIN, 15'd32767, 8'h00, 15'd0, 1'b1, '{ST_FULL, 15'd0, 8'h00, 1'b0}},
			'{OP_PUT_BEGIN, 15'd0, 8'h00, 15'd0, 1'b1, '{ST_OK, 15'd0, 8'h00, 1'b1}},
			'{OP_GET_BEGIN, 15'd0, 8'h00, 15'd0, 1'b1, '{ST_OK, 15'd0, 8'h00, 1'b1}},
			'{OP_PUT_BEGIN, 15'd3, 8'h00, 15'd0, 1'b0, '0},
			'{OP_PUT_BYTE, 15'd0, 8'h00, 15'd0, 1'b0, '0},
			'{OP_PUT_BYTE, 15'd0, 8'hff, 15'd0, 1'b0, '0},
			'{OP_PUT_BYTE, 15'd0, 8'ha5, 15'd0, 1'b0, '0},
			'{OP_GET_BEGIN, 15'd0, 8'h00, 15'd2, 1'b1, '{ST_TOO_LONG, 15'd3, 8'h00, 1'b0}},
			'{OP_GET_BEGIN, 15'd0, 8'h00, 15'd32767, 1'b0, '0},
			'{OP_GET_BYTE, 15'd0, 8'h00, 15'd0, 1'b0, '0},
			'{OP_GET_BYTE, 15'd0, 8'h00, 15'd0, 1'b0, '0},
			'{OP_GET_BYTE, 15'd0, 8'h00, 15'd0, 1'b0, '0},
			'{OP_GET_BEGIN, 15'd0, 8'h00, 15'd32767, 1'b1, '{ST_EMPTY, 15'd0, 8'h00, 1'b0}},
			'{OP_PUT_BEGIN, 15'd2, 8'h00, 15'd0, 1'b0, '0},
			'{OP_PUT_BYTE, 15'd0, 8'h5a, 15'd0, 1'b0, '0},
			'{OP_PUT_BEGIN, 15'd1, 8'h00, 15'd0, 1'b0, '0},
			'{OP_PUT_BYTE, 15'd0, 8'h3c, 15'd0, 1'b0, '0},
			'{OP_GET_BEGIN, 15'd0, 8'h00, 15'd32764, 1'b0, '0},
			'{OP_GET_BEGIN, 15'd0, 8'h00, 15'd32764, 1'b0, '0},
			'{OP_GET_BYTE, 15'd0, 8'h00, 15'd0, 1'b0, '0},
			'{OP_PUT_BEGIN, 15'd32762, 8'h00, 15'd0, 1'b1, '{ST_FULL, 15'd0, 8'h00, 1'b0}},
			'{OP_PUT_BEGIN, 15'd32761, 8'h00, 15'd0, 1'b1, '{ST_OK, 15'd0, 8'h00, 1'b0}}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 25; i++)
			offer_op(dir_rows[i].cmd, dir_rows[i].len, dir_rows[i].din, dir_rows[i].lim,
				dir_rows[i].typed, dir_rows[i].want);
		random_traffic(480);
		settle();

		send_idle = 81;
		recv_idle = 13;
		random_traffic(220);
		settle();
		random_traffic(220);
		settle();

		send_idle = 0;
		recv_idle = 0;
		random_traffic(100);
		// long output stall while transactions keep coming
		stall_left = 300;
		random_traffic(150);
		settle();

		// drain what is left
		forever begin
			d = wr_off - ((rd_off + 32'd3) & ~32'd3);
			if (d == 32'd0 || d[31])
				break;
			get_message(15'h7fff, 1'b1);
		end

		settle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ length_prefixed_message_ring_core.f @@
hdl/lpmr_pkg.sv
hdl/lpmr_ram.sv
hdl/lpmr_ctrl.sv
hdl/lpmr_dp.sv
hdl/length_prefixed_message_ring.sv
dv/tb_length_prefixed_message_ring_core.sv
